>>> design/rabs_pkg.sv
`timescale 1ns / 1ps
package rabs_pkg;
    localparam int NumW  = 35;  // corner minus origin
    localparam int DivW  = 51;  // numerator scaled by 2^16
    localparam int QW    = 32;
    localparam int DistW = 31;
endpackage

>>> design/rabs_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider on magnitudes, one quotient bit a stage,
// signed result truncated toward zero then saturated to 32 bits.
module rabs_div
    import rabs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [NumW-1:0] i_num,
    input  logic signed [QW-1:0]   i_den,
    output logic signed [QW-1:0]   o_q
);
    localparam int S = DivW;
    logic [S-1:0] r_n   [0:S];
    logic [S-1:0] r_q   [0:S];
    logic [QW:0]  r_d   [0:S];
    logic         r_neg [0:S];
    logic [QW:0]  r_rem [0:S];
    logic signed [NumW-1:0] w_an;
    logic signed [QW:0]     w_ad;

    always_comb begin
        w_an = i_num[NumW-1] ? -i_num : i_num;
        w_ad = i_den[QW-1] ? -{i_den[QW-1], i_den} : {i_den[QW-1], i_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= {w_an[NumW-2:0], 16'd0};
            r_q[0]   <= '0;
            r_rem[0] <= '0;
            r_d[0]   <= w_ad;
            r_neg[0] <= i_num[NumW-1] ^ i_den[QW-1];
        end
    end

    for (genvar k = 0; k < S; k++) begin : g_st
        logic [QW+1:0] w_t;
        logic [QW+1:0] w_s;
        always_comb begin
            w_t = {r_rem[k], r_n[k][S-1-k]};
            w_s = w_t - {1'b0, r_d[k]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k+1]   <= r_n[k];
                r_d[k+1]   <= r_d[k];
                r_neg[k+1] <= r_neg[k];
                if (!w_s[QW+1]) begin
                    r_rem[k+1] <= w_s[QW:0];
                    r_q[k+1]   <= {r_q[k][S-2:0], 1'b1};
                end else begin
                    r_rem[k+1] <= w_t[QW:0];
                    r_q[k+1]   <= {r_q[k][S-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        if (r_neg[S]) begin
            o_q = (r_q[S] > {{(S-QW){1'b0}}, 1'b1, {(QW-1){1'b0}}})
                  ? {1'b1, {(QW-1){1'b0}}} : QW'(-r_q[S]);
        end else begin
            o_q = (r_q[S] > {{(S-QW+1){1'b0}}, {(QW-1){1'b1}}})
                  ? {1'b0, {(QW-1){1'b1}}} : r_q[S][QW-1:0];
        end
    end
endmodule

>>> design/ray_aabb_slab_intersect.sv
`timescale 1ns / 1ps
// Ray versus box slab test, Q16.16. One beat in and one result out per cycle
// while not stalled; the pipe is an input stage for corners and numerators,
// the six pipelined restoring dividers (an operand stage then one quotient bit
// per stage for 51 stages), plus a min/max and a select stage. A stall
// freezes the whole pipe; the output register holds while stalled.
module ray_aabb_slab_intersect
    import rabs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic signed [31:0]    i_box_center_x,
    input  logic signed [31:0]    i_box_center_y,
    input  logic signed [31:0]    i_box_center_z,
    input  logic signed [31:0]    i_half_extent_x,
    input  logic signed [31:0]    i_half_extent_y,
    input  logic signed [31:0]    i_half_extent_z,
    input  logic signed [31:0]    i_origin_x,
    input  logic signed [31:0]    i_origin_y,
    input  logic signed [31:0]    i_origin_z,
    input  logic signed [31:0]    i_dir_x,
    input  logic signed [31:0]    i_dir_y,
    input  logic signed [31:0]    i_dir_z,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_hit,
    output logic [DistW-1:0]      o_hit_distance
);
    localparam int Lat = DivW + 4;
    logic w_en;
    logic [Lat-1:0] r_vld;
    logic signed [31:0] w_c [3], w_e [3], w_o [3], w_d [3];
    logic signed [NumW-1:0] r_lo [3], r_hi [3];
    logic signed [31:0] r_dd [3];
    logic signed [QW-1:0] w_t1 [3], w_t2 [3];
    logic signed [QW-1:0] r_tmin, r_tmax, w_nr [3], w_fr [3], n_tmin, n_tmax;
    logic r_hit;
    logic [DistW-1:0] r_dist;

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[Lat-1];
    assign o_hit = r_hit;
    assign o_hit_distance = r_dist;
    assign w_c = '{i_box_center_x, i_box_center_y, i_box_center_z};
    assign w_e = '{i_half_extent_x, i_half_extent_y, i_half_extent_z};
    assign w_o = '{i_origin_x, i_origin_y, i_origin_z};
    assign w_d = '{i_dir_x, i_dir_y, i_dir_z};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[Lat-2:0], i_valid};
        end
    end

    for (genvar a = 0; a < 3; a++) begin : g_ax
        logic signed [33:0] w_p, w_m;
        always_comb begin
            w_p = 34'(w_c[a]) + 34'(w_e[a]);
            w_m = 34'(w_c[a]) - 34'(w_e[a]);
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_lo[a] <= (w_p < w_m ? NumW'(w_p) : NumW'(w_m)) - NumW'(w_o[a]);
                r_hi[a] <= (w_p < w_m ? NumW'(w_m) : NumW'(w_p)) - NumW'(w_o[a]);
                r_dd[a] <= (w_d[a] == 0) ? 32'sd1 : w_d[a];
            end
        end
        rabs_div u_d1 (.i_clk, .i_en(w_en), .i_num(r_lo[a]), .i_den(r_dd[a]),
                       .o_q(w_t1[a]));
        rabs_div u_d2 (.i_clk, .i_en(w_en), .i_num(r_hi[a]), .i_den(r_dd[a]),
                       .o_q(w_t2[a]));
        assign w_nr[a] = w_t1[a] < w_t2[a] ? w_t1[a] : w_t2[a];
        assign w_fr[a] = w_t1[a] < w_t2[a] ? w_t2[a] : w_t1[a];
    end

    always_comb begin
        n_tmin = w_nr[0];
        n_tmax = w_fr[0];
        for (int a = 1; a < 3; a++) begin
            if (w_nr[a] > n_tmin) n_tmin = w_nr[a];
            if (w_fr[a] < n_tmax) n_tmax = w_fr[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tmin <= n_tmin;
            r_tmax <= n_tmax;
            if (r_tmax < 0 || r_tmin > r_tmax) begin
                r_hit  <= 1'b0;
                r_dist <= '0;
            end else begin
                r_hit  <= 1'b1;
                r_dist <= r_tmin < 0 ? r_tmax[DistW-1:0] : r_tmin[DistW-1:0];
            end
        end
    end

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_hit_distance == '0) else $error("miss with distance");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_hit_distance))
        else $error("output moved under stall");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall) else $error("spurious stall");
endmodule
